// ===== hw/rtl/aadpm_pkg.sv =====
// ----------------------------------------------------------------------------
// aadpm_pkg
// Shared widths, register indexes, reset values and types for the audio
// sample to PWM compare mapper.
// ----------------------------------------------------------------------------
package aadpm_pkg;

	// Fixed field widths
	localparam int COEFF_W    = 16;
	localparam int GAIN_W     = 9;
	localparam int CENTER_W   = 9;
	localparam int LIMIT_W    = 10;
	localparam int DUTY_W     = 10;
	localparam int GAIN_FRAC  = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_COEFF = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_Q8      = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_CENTER   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] CFG_PWM_LIMIT    = CFG_IDX_W'(3);

	// Register reset values
	localparam logic [COEFF_W-1:0]  RST_FILTER_COEFF = COEFF_W'(3874);
	localparam logic [GAIN_W-1:0]   RST_GAIN_Q8      = GAIN_W'(256);
	localparam logic [CENTER_W-1:0] RST_PWM_CENTER   = CENTER_W'(212);
	localparam logic [LIMIT_W-1:0]  RST_PWM_LIMIT    = LIMIT_W'(424);

	typedef logic [DUTY_W-1:0] duty_t;

	// Frame sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILT_MUL,
		ST_FILT_ACC,
		ST_LANE_MUL,
		ST_LANE_SCALE,
		ST_DONE
	} aadpm_state_t;

	// Low-pass filter step controls
	typedef struct packed {
		logic mul_en;
		logic upd_en;
	} lp_ctrl_t;

endpackage

// ===== hw/rtl/aadpm_lowpass.sv =====
// ----------------------------------------------------------------------------
// aadpm_lowpass
// One-pole low-pass filter for the bass channel, two multiply steps:
// y = (a*x + (65536-a)*prev) >> 16, truncated. y becomes the new state.
// ----------------------------------------------------------------------------
module aadpm_lowpass #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  aadpm_pkg::lp_ctrl_t             ctrl,
	input  logic [aadpm_pkg::COEFF_W-1:0]   filter_coeff,
	input  logic [SAMPLE_BITS-1:0]          sample,
	output logic [SAMPLE_BITS-1:0]          filt
);
	import aadpm_pkg::*;

	localparam int PA_W  = COEFF_W + SAMPLE_BITS;
	localparam int ACC_W = COEFF_W + 1 + SAMPLE_BITS;
	localparam logic [COEFF_W:0]       Q_ONE = (COEFF_W+1)'(1) << COEFF_W;
	localparam logic [SAMPLE_BITS-1:0] MID   = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

	logic [PA_W-1:0]        prod_a_s1;
	logic [COEFF_W:0]       weight_b;
	logic [ACC_W-1:0]       acc;
	logic [SAMPLE_BITS-1:0] prev_q;

	// First step: weight the new sample
	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			prod_a_s1 <= filter_coeff * sample;
		end
	end

	// Second step: add the weighted previous output
	always_comb begin
		weight_b = Q_ONE - {1'b0, filter_coeff};
		acc      = {1'b0, prod_a_s1} + weight_b * prev_q;
	end

	// Hold the filter state, advance it once per frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= MID;
		end else if (ctrl.upd_en) begin
			prev_q <= acc[COEFF_W +: SAMPLE_BITS];
		end
	end

	assign filt = prev_q;

endmodule

// ===== hw/rtl/aadpm_lane.sv =====
// ----------------------------------------------------------------------------
// aadpm_lane
// Maps one channel sample to a PWM compare value: remove the midpoint,
// apply the Q8 gain, scale by center / midpoint, add center and clamp.
// Two registered multiply stages, the final add and clamp are combinational.
// ----------------------------------------------------------------------------
module aadpm_lane #(
	parameter int SAMPLE_BITS = 12
) (
	input  logic                            clk,
	input  logic [SAMPLE_BITS-1:0]          sample,
	input  logic [aadpm_pkg::GAIN_W-1:0]    gain_q8,
	input  logic [aadpm_pkg::CENTER_W-1:0]  pwm_center,
	input  logic [aadpm_pkg::LIMIT_W-1:0]   pwm_limit,
	output aadpm_pkg::duty_t                duty
);
	import aadpm_pkg::*;

	localparam int P1_W  = SAMPLE_BITS + 1 + GAIN_W + 1;
	localparam int SC_W  = P1_W - GAIN_FRAC;
	localparam int P2_W  = SC_W + CENTER_W + 1;
	localparam int OFF_W = P2_W - (SAMPLE_BITS - 1);
	localparam int VAL_W = OFF_W + 1;
	localparam logic [SAMPLE_BITS:0] MID_EXT = (SAMPLE_BITS+1)'(1) << (SAMPLE_BITS - 1);
	localparam logic [P1_W-1:0] RND1 = P1_W'((1 << GAIN_FRAC) - 1);
	localparam logic [P2_W-1:0] RND2 = P2_W'((1 << (SAMPLE_BITS - 1)) - 1);

	logic signed [SAMPLE_BITS:0] offset;
	logic signed [P1_W-1:0]      prod1;
	logic signed [P1_W-1:0]      prod1_s1;
	logic [P1_W-1:0]             sum1;
	logic signed [SC_W-1:0]      scaled;
	logic signed [P2_W-1:0]      prod2;
	logic signed [P2_W-1:0]      prod2_s2;
	logic [P2_W-1:0]             sum2;
	logic signed [OFF_W-1:0]     pwm_off;
	logic signed [VAL_W-1:0]     value;

	// Signed offset times gain
	always_comb begin
		offset = $signed({1'b0, sample}) - $signed(MID_EXT);
		prod1  = offset * $signed({1'b0, gain_q8});
	end

	always_ff @(posedge clk) begin
		prod1_s1 <= prod1;
	end

	// Divide by 256 toward zero, then scale by center
	always_comb begin
		sum1   = prod1_s1 + (prod1_s1[P1_W-1] ? RND1 : '0);
		scaled = $signed(sum1[P1_W-1:GAIN_FRAC]);
		prod2  = scaled * $signed({1'b0, pwm_center});
	end

	always_ff @(posedge clk) begin
		prod2_s2 <= prod2;
	end

	// Divide by the midpoint toward zero, add center, clamp to 0..limit
	always_comb begin
		sum2    = prod2_s2 + (prod2_s2[P2_W-1] ? RND2 : '0);
		pwm_off = $signed(sum2[P2_W-1:SAMPLE_BITS-1]);
		value   = $signed({{(VAL_W-CENTER_W){1'b0}}, pwm_center})
			+ $signed({pwm_off[OFF_W-1], pwm_off});
		if (value[VAL_W-1]) begin
			duty = '0;
		end else if (value[VAL_W-2:0] > {{(VAL_W-1-LIMIT_W){1'b0}}, pwm_limit}) begin
			duty = pwm_limit;
		end else begin
			duty = value[DUTY_W-1:0];
		end
	end

endmodule

// ===== hw/rtl/aadpm_merge.sv =====
// ----------------------------------------------------------------------------
// aadpm_merge
// Collects the compare values of all lanes into one output word and holds
// it in the output register until the downstream side takes it.
// ----------------------------------------------------------------------------
module aadpm_merge #(
	parameter int NUM_CHANNELS = 3
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aadpm_pkg::duty_t      duty [NUM_CHANNELS],
	input  logic                  load,
	input  logic                  out_tready,
	output logic                  out_tvalid,
	output logic [((NUM_CHANNELS*aadpm_pkg::DUTY_W+7)/8)*8-1:0] out_tdata,
	output logic                  slot_free
);
	import aadpm_pkg::*;

	localparam int OUT_W = ((NUM_CHANNELS * DUTY_W + 7) / 8) * 8;

	logic [OUT_W-1:0] packed_data;
	logic [OUT_W-1:0] data_q;
	logic             valid_q;

	// Pack lanes, first channel in the lowest bits
	always_comb begin
		packed_data = '0;
		for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
			packed_data[ch*DUTY_W +: DUTY_W] = duty[ch];
		end
	end

	// Hold the result until the transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= packed_data;
		end
	end

	assign slot_free  = !valid_q || out_tready;
	assign out_tvalid = valid_q;
	assign out_tdata  = data_q;

endmodule

// ===== hw/rtl/audio_adc_to_pwm_mapper.sv =====
// ----------------------------------------------------------------------------
// audio_adc_to_pwm_mapper
// Maps a frame of ADC samples to class-D PWM compare values, with a one-pole
// low-pass filter on the last (bass) channel.
// ----------------------------------------------------------------------------
// One frame is taken at a time and yields one word of compare values. A
// frame passes, from its transaction to the next frame being taken, through
// two filter multiply steps, two lane multiply stages, the clamp into the
// output register and the return to idle. A result still waiting downstream
// stretches this until the output register frees up. All channels run in
// parallel lanes, so the sequence does not depend on NUM_CHANNELS. Write
// configuration only while no frame is in flight.
module audio_adc_to_pwm_mapper #(
	parameter int SAMPLE_BITS  = 12,
	parameter int NUM_CHANNELS = 3,
	localparam int IN_W  = ((NUM_CHANNELS * SAMPLE_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((NUM_CHANNELS * aadpm_pkg::DUTY_W + 7) / 8) * 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// sample_first, sample_second, sample_bass (bass last)
	input  logic [IN_W-1:0]                    s_axis_tdata,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// duty_first, duty_second, duty_bass (bass last)
	output logic [OUT_W-1:0]                   m_axis_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [aadpm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [aadpm_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import aadpm_pkg::*;

	localparam int FRAME_W = NUM_CHANNELS * SAMPLE_BITS;

	aadpm_state_t              state_q;
	aadpm_state_t              state_d;
	logic [FRAME_W-1:0]        samp_q;
	logic [COEFF_W-1:0]        filter_coeff_q;
	logic [GAIN_W-1:0]         gain_q8_q;
	logic [CENTER_W-1:0]       pwm_center_q;
	logic [LIMIT_W-1:0]        pwm_limit_q;
	lp_ctrl_t                  lp_ctrl;
	logic [SAMPLE_BITS-1:0]    bass_filt;
	duty_t                     duty [NUM_CHANNELS];
	logic                      slot_free;
	logic                      load;
	logic                      in_accept;

	assign in_accept = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_coeff_q <= RST_FILTER_COEFF;
			gain_q8_q      <= RST_GAIN_Q8;
			pwm_center_q   <= RST_PWM_CENTER;
			pwm_limit_q    <= RST_PWM_LIMIT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_FILTER_COEFF: filter_coeff_q <= cfg_data[COEFF_W-1:0];
				CFG_GAIN_Q8:      gain_q8_q      <= cfg_data[GAIN_W-1:0];
				CFG_PWM_CENTER:   pwm_center_q   <= cfg_data[CENTER_W-1:0];
				CFG_PWM_LIMIT:    pwm_limit_q    <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	// Capture the frame on its transaction
	always_ff @(posedge clk) begin
		if (in_accept) begin
			samp_q <= s_axis_tdata[FRAME_W-1:0];
		end
	end

	// Frame sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		s_axis_tready  = 1'b0;
		lp_ctrl.mul_en = 1'b0;
		lp_ctrl.upd_en = 1'b0;
		load           = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = ST_FILT_MUL;
				end
			end
			ST_FILT_MUL: begin
				lp_ctrl.mul_en = 1'b1;
				state_d        = ST_FILT_ACC;
			end
			ST_FILT_ACC: begin
				lp_ctrl.upd_en = 1'b1;
				state_d        = ST_LANE_MUL;
			end
			ST_LANE_MUL: begin
				state_d = ST_LANE_SCALE;
			end
			ST_LANE_SCALE: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (slot_free) begin
					load    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Bass filter
	aadpm_lowpass #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lowpass (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (lp_ctrl),
		.filter_coeff (filter_coeff_q),
		.sample       (samp_q[(NUM_CHANNELS-1)*SAMPLE_BITS +: SAMPLE_BITS]),
		.filt         (bass_filt)
	);

	// One mapping lane per channel, the last one fed by the filter
	for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
		logic [SAMPLE_BITS-1:0] lane_in;

		if (ch == NUM_CHANNELS - 1) begin : g_bass
			assign lane_in = bass_filt;
		end else begin : g_plain
			assign lane_in = samp_q[ch*SAMPLE_BITS +: SAMPLE_BITS];
		end

		aadpm_lane #(
			.SAMPLE_BITS (SAMPLE_BITS)
		) u_lane (
			.clk        (clk),
			.sample     (lane_in),
			.gain_q8    (gain_q8_q),
			.pwm_center (pwm_center_q),
			.pwm_limit  (pwm_limit_q),
			.duty       (duty[ch])
		);
	end

	// Merge lanes into the output register
	aadpm_merge #(
		.NUM_CHANNELS (NUM_CHANNELS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.duty       (duty),
		.load       (load),
		.out_tready (m_axis_tready),
		.out_tvalid (m_axis_tvalid),
		.out_tdata  (m_axis_tdata),
		.slot_free  (slot_free)
	);

	// A frame transaction starts the filter step
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> state_q == ST_FILT_MUL)
		else $error("frame transaction did not start the sequencer");

	// The filter state moves only at its update step
	a_filt_update: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(bass_filt) |-> $past(state_q == ST_FILT_ACC))
		else $error("bass filter state changed outside its update step");

	// A new result appears only when the sequencer finishes a frame
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
		else $error("output valid rose without a finished frame");

	// A finished frame never overwrites a waiting result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(load && m_axis_tvalid) |-> m_axis_tready)
		else $error("result loaded over a pending transaction");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the audio sample to PWM compare mapper. Frames go in
// on the sample stream, compare words come back on the duty stream, and each
// word is checked field by field against a local model. The model tracks
// the bass low-pass state and the register settings. The run covers reset
// values, the clamps, the filter extremes, masked and ignored register
// writes, many random settings, and a long output stall that fills the block.
// ----------------------------------------------------------------------------
module tb_top;
	import aadpm_pkg::*;

	localparam int SMP_W          = 12;
	localparam int IN_W           = 40;
	localparam int OUT_W          = 32;
	localparam int MID_CODE       = 2048;
	localparam int Q8_ONE         = 256;
	localparam int Q16_ONE        = 65536;
	localparam int MAX_GAP        = 13;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int HOLD_CYCLES    = 400;
	localparam int RAND_PHASES    = 11;
	localparam int PHASE_FRAMES   = 150;
	localparam int PRESSURE_FRAMES = 40;

	typedef logic [SMP_W-1:0] sample_t;

	typedef struct packed {
		duty_t first;
		duty_t second;
		duty_t bass;
	} duty_frame_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	// sample_first, sample_second, sample_bass, zero pad
	logic [IN_W-1:0]   s_axis_tdata;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	// duty_first, duty_second, duty_bass, zero pad
	logic [OUT_W-1:0]  m_axis_tdata;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Model copy of the registers and the filter state
	logic [COEFF_W-1:0]  coeff_m;
	logic [GAIN_W-1:0]   gain_m;
	logic [CENTER_W-1:0] center_m;
	logic [LIMIT_W-1:0]  limit_m;
	sample_t             bass_prev_m;

	duty_frame_t duty_q[$];

	int  errors;
	int  frames_sent;
	int  results_checked;
	int  reg_writes;
	int  hold_request;
	int  holds_done;
	bit  no_idle;

	audio_adc_to_pwm_mapper u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// One-pole low-pass on the bass sample, Q16 weight
	function automatic sample_t lowpass_step(sample_t x);
		longint unsigned acc;
		acc = longint'(coeff_m) * longint'(x)
			+ (longint'(Q16_ONE) - longint'(coeff_m)) * longint'(bass_prev_m);
		return acc[27:16];
	endfunction

	// Offset, gain, scale to the center, add the center, clamp
	function automatic duty_t duty_of(sample_t s);
		int offset;
		int scaled;
		int pwm_off;
		int value;
		offset  = int'(s) - MID_CODE;
		scaled  = (offset * int'(gain_m)) / Q8_ONE;
		pwm_off = (scaled * int'(center_m)) / MID_CODE;
		value   = int'(center_m) + pwm_off;
		if (value > int'(limit_m)) begin
			value = int'(limit_m);
		end
		if (value < 0) begin
			value = 0;
		end
		return duty_t'(value);
	endfunction

	task automatic report_fail(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	// Offer one frame, predict its compare word on acceptance
	task automatic send_frame(input sample_t first, input sample_t second, input sample_t bass);
		int          gap;
		duty_frame_t want;
		sample_t     filt;
		gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= IN_W'({bass, second, first});
		do @(posedge clk); while (!s_axis_tready);
		filt        = lowpass_step(bass);
		bass_prev_m = filt;
		want.first  = duty_of(first);
		want.second = duty_of(second);
		want.bass   = duty_of(filt);
		duty_q.push_back(want);
		frames_sent++;
	endtask

	// Drop valid and wait until every compare word has come back
	task automatic drain_frames();
		s_axis_tvalid <= 1'b0;
		while (duty_q.size() != 0) @(posedge clk);
	endtask

	// One register transaction once no frame is in flight; the model follows
	// the block's masking
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		drain_frames();
		repeat ($urandom_range(1, 3)) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FILTER_COEFF: coeff_m  = data[COEFF_W-1:0];
			CFG_GAIN_Q8:      gain_m   = data[GAIN_W-1:0];
			CFG_PWM_CENTER:   center_m = data[CENTER_W-1:0];
			CFG_PWM_LIMIT:    limit_m  = data[LIMIT_W-1:0];
			default: ;
		endcase
		reg_writes++;
	endtask

	// Write all four registers; spare upper data bits carry random junk
	task automatic apply_config(input int unsigned coeff, input int unsigned gain,
			input int unsigned center, input int unsigned limit);
		logic [CFG_DATA_W-1:0] junk;
		junk = CFG_DATA_W'($urandom);
		write_reg(CFG_FILTER_COEFF, CFG_DATA_W'(coeff));
		write_reg(CFG_GAIN_Q8, {junk[15:GAIN_W], GAIN_W'(gain)});
		junk = CFG_DATA_W'($urandom);
		write_reg(CFG_PWM_CENTER, {junk[15:CENTER_W], CENTER_W'(center)});
		junk = CFG_DATA_W'($urandom);
		write_reg(CFG_PWM_LIMIT, {junk[15:LIMIT_W], LIMIT_W'(limit)});
	endtask

	function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
		case ($urandom_range(0, 5))
			0: return lo;
			1: return hi;
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	// Mostly uniform samples, with rails and the midpoint mixed in
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: return sample_t'(0);
			1: return sample_t'(4095);
			2: return sample_t'(MID_CODE);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Test tasks
	// ------------------------------------------------------------------
	task automatic test_reset_values();
		send_frame(sample_t'(MID_CODE), sample_t'(MID_CODE), sample_t'(MID_CODE));
		send_frame(sample_t'(0), sample_t'(0), sample_t'(0));
		send_frame(sample_t'(4095), sample_t'(4095), sample_t'(4095));
		send_frame(sample_t'(0), sample_t'(4095), sample_t'(4095));
		send_frame(sample_t'(4095), sample_t'(0), sample_t'(0));
		drain_frames();
	endtask

	task automatic test_clamps();
		// Large negative swing drives the sum below zero
		apply_config(3874, 384, 300, 1023);
		send_frame(sample_t'(0), sample_t'(4095), sample_t'(0));
		// Tight limit catches the positive swing
		apply_config(65535, 256, 400, 100);
		send_frame(sample_t'(4095), sample_t'(0), sample_t'(4095));
		// Widest center and limit
		apply_config(32768, 256, 511, 1023);
		send_frame(sample_t'(4095), sample_t'(0), sample_t'(4095));
		// Zero center, limit of one, zero gain
		apply_config(1, 0, 0, 1);
		send_frame(sample_t'(4095), sample_t'(0), sample_t'(MID_CODE));
		drain_frames();
	endtask

	task automatic test_limit_zero();
		apply_config(3874, 256, 212, 0);
		send_frame(sample_t'(4095), sample_t'(MID_CODE), sample_t'(0));
		send_frame(sample_t'(0), sample_t'(4095), sample_t'(4095));
		drain_frames();
	endtask

	task automatic test_gain_overrange();
		apply_config(3874, 256, 212, 1023);
		write_reg(CFG_GAIN_Q8, 16'hFFFF);
		send_frame(sample_t'(4095), sample_t'(0), sample_t'(4095));
		send_frame(sample_t'(2100), sample_t'(1990), sample_t'(0));
		drain_frames();
	endtask

	task automatic test_filter_extremes();
		// Zero weight holds the state whatever the input
		apply_config(0, 256, 212, 424);
		send_frame(sample_t'(MID_CODE), sample_t'(MID_CODE), sample_t'(4095));
		send_frame(sample_t'(MID_CODE), sample_t'(MID_CODE), sample_t'(0));
		// Full weight nearly tracks the input
		write_reg(CFG_FILTER_COEFF, 16'hFFFF);
		send_frame(sample_t'(MID_CODE), sample_t'(MID_CODE), sample_t'(4095));
		send_frame(sample_t'(MID_CODE), sample_t'(MID_CODE), sample_t'(4095));
		send_frame(sample_t'(MID_CODE), sample_t'(MID_CODE), sample_t'(0));
		drain_frames();
	endtask

	task automatic test_unused_index();
		logic [CFG_IDX_W-1:0] idx;
		write_reg(CFG_IDX_W'(4), 16'hFFFF);
		write_reg(CFG_IDX_W'(255), 16'h0000);
		repeat (6) begin
			idx = CFG_IDX_W'($urandom_range(4, 255));
			write_reg(idx, CFG_DATA_W'($urandom));
		end
		send_frame(sample_t'(1000), sample_t'(3000), sample_t'(3500));
		send_frame(sample_t'($urandom), sample_t'($urandom), sample_t'($urandom));
		drain_frames();
	endtask

	task automatic test_random_settings();
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			apply_config(pick_value(0, 65535), (ph == 4) ? 511 : pick_value(0, 384),
				pick_value(0, 511), pick_value(1, 1023));
			no_idle = (ph % 4 == 2);
			repeat (PHASE_FRAMES) begin
				send_frame(pick_sample(), pick_sample(), pick_sample());
			end
			drain_frames();
			no_idle = 1'b0;
		end
	endtask

	task automatic test_backpressure();
		apply_config(3874, 256, 212, 424);
		no_idle      = 1'b1;
		hold_request = HOLD_CYCLES;
		repeat (PRESSURE_FRAMES) begin
			send_frame(pick_sample(), pick_sample(), pick_sample());
		end
		drain_frames();
		no_idle = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		coeff_m       = RST_FILTER_COEFF;
		gain_m        = RST_GAIN_Q8;
		center_m      = RST_PWM_CENTER;
		limit_m       = RST_PWM_LIMIT;
		bass_prev_m   = sample_t'(MID_CODE);
		errors        = 0;
		frames_sent   = 0;
		results_checked = 0;
		reg_writes    = 0;
		hold_request  = 0;
		holds_done    = 0;
		no_idle       = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_clamps();
		test_limit_zero();
		test_gain_overrange();
		test_filter_extremes();
		test_unused_index();
		test_random_settings();
		test_backpressure();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (duty_q.size() != 0) begin
			report_fail($sformatf("%0d compare words never arrived", duty_q.size()));
		end
		$display("run: %0d frames, %0d compare words checked, %0d register writes",
			frames_sent, results_checked, reg_writes);
		$display("run: clamps, filter extremes, ignored indexes, %0d long output stall(s)",
			holds_done);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Output side: random stalls per word, one long hold-off on request
	initial begin : duty_sink
		int stall;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				m_axis_tready <= 1'b0;
				repeat (hold_request) @(posedge clk);
				hold_request = 0;
				holds_done++;
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
				if (stall > 0) begin
					m_axis_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// Compare each accepted word with the oldest prediction
	always @(posedge clk) begin : duty_check
		duty_frame_t got;
		duty_frame_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.first  = m_axis_tdata[DUTY_W-1:0];
			got.second = m_axis_tdata[2*DUTY_W-1:DUTY_W];
			got.bass   = m_axis_tdata[3*DUTY_W-1:2*DUTY_W];
			if (duty_q.size() == 0) begin
				report_fail($sformatf("unexpected compare word %h", m_axis_tdata));
			end else begin
				want = duty_q.pop_front();
				results_checked++;
				if (got.first !== want.first) begin
					report_fail($sformatf("duty_first got %0d want %0d", got.first, want.first));
				end
				if (got.second !== want.second) begin
					report_fail($sformatf("duty_second got %0d want %0d",
						got.second, want.second));
				end
				if (got.bass !== want.bass) begin
					report_fail($sformatf("duty_bass got %0d want %0d", got.bass, want.bass));
				end
			end
		end
	end

	// End the run when no transaction moves for too long
	initial begin : watchdog
		int idle_cycles;
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("FAILURE");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
hw/rtl/aadpm_pkg.sv
hw/rtl/aadpm_lowpass.sv
hw/rtl/aadpm_lane.sv
hw/rtl/aadpm_merge.sv
hw/rtl/audio_adc_to_pwm_mapper.sv
tb/sv/tb_top.sv
